/* design/even_fibonacci_sum_mod_prime_defines.svh */
// Assertion macros shared by the checker of the even Fibonacci sum block.
`ifndef EVEN_FIBONACCI_SUM_MOD_PRIME_DEFINES_SVH
`define EVEN_FIBONACCI_SUM_MOD_PRIME_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFSMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efsmp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EFSMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efsmp assertion failed");

`endif

/* design/efsmp_pkg.sv */
// Package with widths, modulus constants and controller/datapath types.
`timescale 1ns / 1ps

package efsmp_pkg;

    localparam int UPPER_INDEX_W = 63;
    localparam int EVEN_SUM_W    = 30;

    localparam logic [29:0] PRIME_MOD    = 30'd1000000007;
    localparam logic [31:0] PRIME_MOD_X2 = 32'd2000000014;

    // Barrett factor floor(2^61 / P); it fits in 32 bits.
    localparam logic [63:0] BARRETT_M_FULL = 64'h2000_0000_0000_0000 / 64'd1000000007;
    localparam logic [31:0] BARRETT_M      = BARRETT_M_FULL[31:0];

    typedef struct packed {
        logic load;
        logic issue;
        logic dest_base;
        logic elem_e01;
        logic shift;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic exp_bit0;
        logic exp_more;
        logic exp_zero;
        logic out_valid;
    } status_t;

endpackage

/* design/efsmp_if.sv */
// Valid/ready channel interfaces for the index input and the sum output.
`timescale 1ns / 1ps

interface efsmp_index_if;
    logic                                 valid;
    logic                                 ready;
    logic [efsmp_pkg::UPPER_INDEX_W-1:0] upper_index;

    modport source (output valid, output upper_index, input ready);
    modport sink   (input valid, input upper_index, output ready);
endinterface

interface efsmp_sum_if;
    logic                              valid;
    logic                              ready;
    logic [efsmp_pkg::EVEN_SUM_W-1:0] even_sum;

    modport source (output valid, output even_sum, input ready);
    modport sink   (input valid, input even_sum, output ready);
endinterface

/* design/efsmp_ctrl.sv */
// Controller that sequences the matrix products of one exponentiation.
`timescale 1ns / 1ps

module efsmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    input  efsmp_pkg::status_t status,
    output efsmp_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_STEP   = 7'b0000010,
        ST_MUL1   = 7'b0000100,
        ST_SQ0    = 7'b0001000,
        ST_SQ1    = 7'b0010000,
        ST_WAIT   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // A set bit multiplies the accumulator; otherwise only the square is needed.
                if (status.exp_bit0)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_MUL1;
                end
                else if (status.exp_more)
                begin
                    cmd.issue     = 1'b1;
                    cmd.dest_base = 1'b1;
                    state_next    = ST_SQ1;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_MUL1:
            begin
                cmd.issue    = 1'b1;
                cmd.elem_e01 = 1'b1;
                if (status.exp_more)
                begin
                    state_next = ST_SQ0;
                end
                else
                begin
                    // Last exponent bit: the base is not squared again.
                    cmd.shift  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_SQ0:
            begin
                cmd.issue     = 1'b1;
                cmd.dest_base = 1'b1;
                state_next    = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.issue     = 1'b1;
                cmd.dest_base = 1'b1;
                cmd.elem_e01  = 1'b1;
                cmd.shift     = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = status.exp_zero ? ST_FINISH : ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/efsmp_dp.sv */
// Datapath: matrix registers, modular product pipeline and output register.
`timescale 1ns / 1ps

module efsmp_dp #(
    parameter int INDEX_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  efsmp_pkg::cmd_t                      cmd,
    input  logic [efsmp_pkg::UPPER_INDEX_W-1:0]  upper_index,
    output efsmp_pkg::status_t                   status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [efsmp_pkg::EVEN_SUM_W-1:0]     even_sum
);

    typedef struct packed {
        logic dest_base;
        logic elem_e01;
    } tag_t;

    // Both matrices are symmetric powers of [[1,1],[1,0]]: only e00 and e01 are kept.
    logic [29:0] acc00_reg;
    logic [29:0] acc01_reg;
    logic [29:0] base00_reg;
    logic [29:0] base01_reg;
    logic [INDEX_BITS-1:0] exp_reg;

    logic [29:0] base11;
    logic [29:0] opa;
    logic [29:0] opb;
    logic [29:0] opc;
    logic [29:0] opd;

    logic [4:0]  vld_reg;
    tag_t        tag1_reg;
    tag_t        tag2_reg;
    tag_t        tag3_reg;
    tag_t        tag4_reg;
    tag_t        tag5_reg;
    logic [59:0] p0_reg;
    logic [59:0] p1_reg;
    logic [60:0] s_reg;
    logic [62:0] qm_full;
    logic [31:0] q_reg;
    logic [31:0] s3_low_reg;
    logic [61:0] qp_full;
    logic [31:0] qp_reg;
    logic [31:0] s4_low_reg;
    logic [31:0] r_reg;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [29:0] res;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [29:0] sum_reg;

    // The 30-bit difference wraps correctly since the true residue is below 2^30.
    assign base11 = (base00_reg >= base01_reg) ? (base00_reg - base01_reg)
                                               : (base00_reg - base01_reg + efsmp_pkg::PRIME_MOD);

    assign opa = cmd.dest_base ? base00_reg : acc00_reg;
    assign opc = cmd.dest_base ? base01_reg : acc01_reg;
    assign opb = cmd.elem_e01 ? base01_reg : base00_reg;
    assign opd = cmd.elem_e01 ? base11 : base01_reg;

    assign qm_full = 63'(s_reg[60:30]) * 63'(efsmp_pkg::BARRETT_M);
    assign qp_full = 62'(q_reg) * 62'(efsmp_pkg::PRIME_MOD);

    // The Barrett quotient is at most three short, so the remainder is below 4P.
    assign r1  = (r_reg >= efsmp_pkg::PRIME_MOD_X2) ? (r_reg - efsmp_pkg::PRIME_MOD_X2) : r_reg;
    assign r2  = (r1 >= {2'b00, efsmp_pkg::PRIME_MOD}) ? (r1 - {2'b00, efsmp_pkg::PRIME_MOD}) : r1;
    assign res = r2[29:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[3:0], cmd.issue};
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg   <= '{dest_base: cmd.dest_base, elem_e01: cmd.elem_e01};
        p0_reg     <= 60'(opa) * 60'(opb);
        p1_reg     <= 60'(opc) * 60'(opd);
        tag2_reg   <= tag1_reg;
        s_reg      <= 61'(p0_reg) + 61'(p1_reg);
        tag3_reg   <= tag2_reg;
        q_reg      <= qm_full[62:31];
        s3_low_reg <= s_reg[31:0];
        tag4_reg   <= tag3_reg;
        qp_reg     <= qp_full[31:0];
        s4_low_reg <= s3_low_reg;
        tag5_reg   <= tag4_reg;
        r_reg      <= s4_low_reg - qp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc00_reg  <= 30'd1;
            acc01_reg  <= 30'd0;
            base00_reg <= 30'd1;
            base01_reg <= 30'd1;
            // The exponent is the index with bit 0 forced high: (n rounded down to even) + 1.
            exp_reg    <= INDEX_BITS'({1'b0, upper_index[efsmp_pkg::UPPER_INDEX_W-1:1], 1'b1});
        end
        else
        begin
            if (vld_reg[4])
            begin
                case ({tag5_reg.dest_base, tag5_reg.elem_e01})
                    2'b00:   acc00_reg  <= res;
                    2'b01:   acc01_reg  <= res;
                    2'b10:   base00_reg <= res;
                    default: base01_reg <= res;
                endcase
            end
            if (cmd.shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Sum of even-indexed terms is F(a) - 1 for the exponent a, with zero wrapping to P - 1.
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            sum_reg <= (acc01_reg == 30'd0) ? (efsmp_pkg::PRIME_MOD - 30'd1)
                                            : (acc01_reg - 30'd1);
        end
    end

    assign status.busy      = |vld_reg;
    assign status.exp_bit0  = exp_reg[0];
    assign status.exp_more  = |exp_reg[INDEX_BITS-1:1];
    assign status.exp_zero  = (exp_reg == '0);
    assign status.out_valid = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign even_sum  = sum_reg;

endmodule

/* design/even_fibonacci_sum_mod_prime.sv */
// Per exponent bit, from bit 0 up, the controller issues products into the modular product
// pipeline and then drains it until it is empty: four issues for a set bit below the highest
// set bit, two for a clear bit below it, and two for the highest set bit, whose base is not squared.
// One item is in work at a time: a new index is taken only after the result is loaded into the
// output register, which waits while an earlier result is still offered and not taken.
// Reset clears the controller and the valid bits only.
`timescale 1ns / 1ps

module even_fibonacci_sum_mod_prime #(
    parameter int INDEX_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    efsmp_index_if.sink         index_ch,
    efsmp_sum_if.source         sum_ch
);

    efsmp_pkg::cmd_t    cmd;
    efsmp_pkg::status_t status;
    logic               in_ready;
    logic               out_valid;
    logic [efsmp_pkg::EVEN_SUM_W-1:0] even_sum;

    efsmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (index_ch.valid),
        .in_ready  (in_ready),
        .out_ready (sum_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    efsmp_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .upper_index (index_ch.upper_index),
        .status      (status),
        .out_ready   (sum_ch.ready),
        .out_valid   (out_valid),
        .even_sum    (even_sum)
    );

    assign index_ch.ready  = in_ready;
    assign sum_ch.valid    = out_valid;
    assign sum_ch.even_sum = even_sum;

endmodule

/* design/efsmp_checker.sv */
// Port-level checker for the even Fibonacci sum block, with its bind.
`timescale 1ns / 1ps
`include "even_fibonacci_sum_mod_prime_defines.svh"

module efsmp_prop_checker (
    input logic          clk,
    input logic          rst_n,
    efsmp_index_if.sink  index_ch,
    efsmp_sum_if.source  sum_ch
);

    // A result that is not taken stays offered.
    `EFSMP_ASSERT_NEXT(a_out_hold, clk, rst_n, sum_ch.valid && !sum_ch.ready, sum_ch.valid)

    // Every result is a proper residue.
    `EFSMP_ASSERT_NOW(a_sum_range, clk, rst_n, sum_ch.valid, sum_ch.even_sum < efsmp_pkg::PRIME_MOD)

    // After an input transfer the block is busy with that item.
    `EFSMP_ASSERT_NEXT(a_busy_after_in, clk, rst_n, index_ch.valid && index_ch.ready, !index_ch.ready)

    // No result appears in the cycle right after an input transfer.
    `EFSMP_ASSERT_NEXT(a_no_early_out, clk, rst_n, index_ch.valid && index_ch.ready, !$rose(sum_ch.valid))

endmodule

bind even_fibonacci_sum_mod_prime efsmp_prop_checker u_efsmp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .index_ch (index_ch),
    .sum_ch   (sum_ch)
);
